[sv/eeld_pkg.sv]
// Package for the edge event lockout debouncer: field widths, register
// indexes and operation codes. No dependencies.
package eeld_pkg;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned SampleW     = 8;
  localparam int unsigned RegW        = 8;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned OutDataW    = 16;

  // Operation codes carried on the input tuser.
  localparam logic OpScan  = 1'b0;
  localparam logic OpFetch = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] RegRisingMask  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegFallingMask = 3'd1;
  localparam logic [CfgAddrW-1:0] RegLockoutMask = 3'd2;
  localparam logic [CfgAddrW-1:0] RegLockoutTime = 3'd3;
  localparam logic [CfgAddrW-1:0] RegTickDivider = 3'd4;

  // Register reset values.
  localparam logic [RegW-1:0] RisingMaskRst  = 8'h00;
  localparam logic [RegW-1:0] FallingMaskRst = 8'h00;
  localparam logic [RegW-1:0] LockoutMaskRst = 8'hff;
  localparam logic [RegW-1:0] LockoutTimeRst = 8'd20;
  localparam logic [RegW-1:0] TickDividerRst = 8'd10;

  typedef logic [RegW-1:0] timer_t;

  typedef struct packed {
    logic [SampleW-1:0] levels;
    logic [SampleW-1:0] events;
  } result_t;

endpackage

[sv/edge_event_lockout_debouncer_unit.sv]
// Top level of the edge event lockout debouncer: edge qualification, lockout
// timers, event latch and a two-entry result queue. Depends on eeld_pkg.
//
//  channel  dir  payload                                   handshake
//  s_axis   in   tuser: operation[0]; tdata: sample[7:0]   tvalid/tready
//  m_axis   out  tdata: events[7:0], levels[15:8]          tvalid/tready
//  cfg      in   cfg_addr_i index, cfg_wdata_i value       cfg_we_i, no wait
//
// One item per cycle while s_axis_tready is high: the whole scan or fetch is
// evaluated in the cycle of its input transfer and the result is written to a
// two-entry output queue. With the queue empty, a result is visible on m_axis
// in the cycle after its input transfer; otherwise it waits behind the older entry.
// s_axis_tready drops only when both queue entries hold results not yet taken.
// Reset (rst_ni low, asynchronous) clears timers, latch, previous sample,
// tick counter and queue, and loads register reset values.
module edge_event_lockout_debouncer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [eeld_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [eeld_pkg::RegW-1:0]       cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [eeld_pkg::SampleW-1:0]    s_axis_tdata,  // [7:0] sample
  input  logic                            s_axis_tuser,  // [0] operation
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [eeld_pkg::OutDataW-1:0]   m_axis_tdata   // [7:0] events, [15:8] levels
);
  import eeld_pkg::*;

  // Configuration registers
  logic [RegW-1:0] rise_mask_q, fall_mask_q, lock_mask_q, lock_time_q, tick_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_mask_q <= RisingMaskRst;
      fall_mask_q <= FallingMaskRst;
      lock_mask_q <= LockoutMaskRst;
      lock_time_q <= LockoutTimeRst;
      tick_div_q  <= TickDividerRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegRisingMask:  rise_mask_q <= cfg_wdata_i;
        RegFallingMask: fall_mask_q <= cfg_wdata_i;
        RegLockoutMask: lock_mask_q <= cfg_wdata_i;
        RegLockoutTime: lock_time_q <= cfg_wdata_i;
        RegTickDivider: tick_div_q  <= cfg_wdata_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // Handshakes
  logic       push, pop;
  logic [1:0] count_q, count_d;

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid & s_axis_tready;
  assign pop           = m_axis_tvalid & m_axis_tready;

  logic               is_fetch;
  logic [SampleW-1:0] sample;
  assign is_fetch = (s_axis_tuser == OpFetch);
  assign sample   = s_axis_tdata;

  // Core state
  logic [SampleW-1:0] prev_q, prev_d;
  timer_t             timer_q [NumChannels];
  timer_t             timer_d [NumChannels];
  logic [RegW-1:0]    tick_cnt_q, tick_cnt_d;
  logic [SampleW-1:0] latch_ev_q, latch_ev_d;
  logic [SampleW-1:0] latch_lv_q, latch_lv_d;

  logic [SampleW-1:0] edges, enable, qual, timer_nz;
  logic               tick;
  timer_t             loaded;
  result_t            res;

  // Edge select: rising where the new bit is high, falling where it is low.
  assign edges = (sample ^ prev_q) & ((sample & rise_mask_q) | (~sample & fall_mask_q));
  assign tick  = (tick_cnt_q == '0);
  assign qual  = edges & enable;

  always_comb begin
    enable   = '0;
    timer_nz = '0;
    for (int i = 0; i < NumChannels; i++) begin
      enable[i]   = (timer_q[i] == '0);
      timer_nz[i] = (timer_q[i] != '0);
    end
  end

  always_comb begin
    prev_d     = prev_q;
    tick_cnt_d = tick_cnt_q;
    latch_ev_d = latch_ev_q;
    latch_lv_d = latch_lv_q;
    loaded     = '0;
    for (int i = 0; i < NumChannels; i++) timer_d[i] = timer_q[i];
    res.events = '0;
    res.levels = '0;

    if (is_fetch) begin
      res.events = latch_ev_q;
      res.levels = (latch_ev_q != '0) ? latch_lv_q : '0;
      if (push) latch_ev_d = '0;
    end else begin
      res.events = qual;
      res.levels = sample;
      if (push) begin
        prev_d = sample;
        if (qual != '0) begin
          latch_ev_d = qual;
          latch_lv_d = sample;
        end
        // A timer loaded on a tick scan also takes that tick.
        for (int i = 0; i < NumChannels; i++) begin
          loaded = (qual[i] && lock_mask_q[i]) ? lock_time_q : timer_q[i];
          timer_d[i] = (tick && loaded != '0) ? loaded - timer_t'(1) : loaded;
        end
        if (tick) begin
          // divider of zero behaves as one
          tick_cnt_d = (tick_div_q == '0) ? '0 : tick_div_q - RegW'(1);
        end else begin
          tick_cnt_d = tick_cnt_q - RegW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      tick_cnt_q <= '0;
      latch_ev_q <= '0;
      latch_lv_q <= '0;
      for (int i = 0; i < NumChannels; i++) timer_q[i] <= '0;
    end else begin
      prev_q     <= prev_d;
      tick_cnt_q <= tick_cnt_d;
      latch_ev_q <= latch_ev_d;
      latch_lv_q <= latch_lv_d;
      for (int i = 0; i < NumChannels; i++) timer_q[i] <= timer_d[i];
    end
  end

  // Two-entry result queue
  result_t qmem [2];
  logic    wr_ptr_q, rd_ptr_q;

  always_comb begin
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) qmem[wr_ptr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = qmem[rd_ptr_q];

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_fetch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && is_fetch) |=> (latch_ev_q == '0))
    else $error("fetch did not clear latched events");

  a_lockout_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !is_fetch && lock_time_q > 8'd1) |=>
      ((timer_nz & $past(qual & lock_mask_q)) == $past(qual & lock_mask_q)))
    else $error("reported event did not start lockout");

  a_locked_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !is_fetch && count_q == 2'd0) |=>
      ((m_axis_tdata[SampleW-1:0] & $past(timer_nz)) == '0))
    else $error("event reported on locked channel");

endmodule
